/* hw/rtl/bppf_pkg.sv */
// bppf_pkg: shared types and constants of the buffered parallel printer feeder
// used by bppf_front, bppf_back and the top level; no dependencies
package bppf_pkg;

   localparam logic [7:0] READY_MASK  = 8'hB0;
   localparam logic [7:0] READY_VALUE = 8'h90;
   localparam logic [7:0] SEVEN_BITS  = 8'h7F;

   // classified request as it travels from front to back
   typedef struct packed {
      logic       intr;
      logic       ready;
      logic [7:0] ch;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } link_type;

   function automatic logic status_ready(input logic [7:0] status);
      return (status & READY_MASK) == READY_VALUE;
   endfunction

endpackage

/* hw/rtl/bppf_ram.sv */
// bppf_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module bppf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bppf_front.sv */
// bppf_front: takes requests, classifies printer status, holds them in a two-entry queue
// depends on bppf_pkg
module bppf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [7:0]        req_char_in,
   input  logic [7:0]        req_printer_status,
   output bppf_pkg::link_type q_link,
   input  logic              q_take
);

   bppf_pkg::op_type slot_ff [2];
   bppf_pkg::op_type op_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic             push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      op_in.intr  = req_mode;
      op_in.ready = bppf_pkg::status_ready(req_printer_status);
      op_in.ch    = req_char_in;
      cnt_in      = cnt_ff + 2'(push) - 2'(q_take);
      wr_in       = push ? !wr_ff : wr_ff;
      rd_in       = q_take ? !rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= op_in;
      end
   end

   assign q_link.valid = (cnt_ff != 2'd0);
   assign q_link.op    = slot_ff[rd_ff];

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_link.valid) else $error("take from empty queue");
`endif

endmodule

/* hw/rtl/bppf_back.sv */
// bppf_back: ring buffer, printing flag and response register of the printer feeder
// depends on bppf_pkg and bppf_ram
module bppf_back #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  bppf_pkg::link_type q_link,
   output logic               q_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_sent,
   output logic [7:0]         rsp_sent_byte,
   output logic               rsp_finished,
   output logic               rsp_accepted,
   output logic               rsp_busy_printing,
   output logic [7:0]         rsp_fill_level
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);
   localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUFFER_DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(BUFFER_DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
   localparam logic [OCC_W-1:0] OCC_ONE   = OCC_W'(1);

   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic             state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             flag_ff, flag_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_sent_ff, rsp_sent_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_fin_ff, rsp_fin_in;
   logic             rsp_acc_ff, rsp_acc_in;
   logic             rsp_busy_ff, rsp_busy_in;
   logic [7:0]       rsp_fill_ff, rsp_fill_in;
   logic             rsp_load;

   logic             out_free, empty, full;
   logic             mem_wr, mem_rd;
   logic [7:0]       mem_rdata;
   bppf_pkg::op_type op;

   assign op       = q_link.op;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign empty    = (occ_ff == '0);
   assign full     = (occ_ff == FULL_OCC);
   assign q_take   = q_link.valid && (state_ff == ST_RUN) && out_free;

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      occ_in       = occ_ff;
      flag_in      = flag_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      rsp_load     = 1'b0;
      rsp_sent_in  = 1'b0;
      rsp_byte_in  = 8'd0;
      rsp_fin_in   = 1'b0;
      rsp_acc_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (state_ff == ST_READ) begin
         if (out_free) begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_sent_in  = 1'b1;
            rsp_byte_in  = mem_rdata & bppf_pkg::SEVEN_BITS;
            state_in     = ST_RUN;
         end
      end else if (q_take) begin
         priority if (!op.intr) begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            if (empty) begin
               if (op.ready) begin
                  rsp_sent_in = 1'b1;
                  rsp_byte_in = op.ch;
                  rsp_acc_in  = 1'b1;
                  flag_in     = 1'b1;
               end
            end else if (!full) begin
               mem_wr     = 1'b1;
               wr_ptr_in  = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_ONE;
               occ_in     = occ_ff + OCC_ONE;
               rsp_acc_in = 1'b1;
            end
         end else if (op.ready && !empty) begin
            mem_rd    = 1'b1;
            rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_ONE;
            occ_in    = occ_ff - OCC_ONE;
            state_in  = ST_READ;
         end else begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            if (op.ready) begin
               rsp_fin_in = 1'b1;
               flag_in    = 1'b0;
            end
         end
      end

      rsp_busy_in = flag_in;
      rsp_fill_in = 8'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         occ_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         occ_ff       <= occ_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sent_ff <= rsp_sent_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_fin_ff  <= rsp_fin_in;
         rsp_acc_ff  <= rsp_acc_in;
         rsp_busy_ff <= rsp_busy_in;
         rsp_fill_ff <= rsp_fill_in;
      end
   end

   bppf_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (op.ch),
      .rd_en   (mem_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sent          = rsp_sent_ff;
   assign rsp_sent_byte     = rsp_byte_ff;
   assign rsp_finished      = rsp_fin_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_busy_printing = rsp_busy_ff;
   assign rsp_fill_level    = rsp_fill_ff;

`ifndef SYNTHESIS
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_OCC) else $error("occupancy above depth");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff)) else $error("pointers differ when empty");
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) && out_free |=> rsp_valid_ff && rsp_sent_ff && (state_ff == ST_RUN))
      else $error("buffered character not delivered");
   a_fin_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_fin_ff && rsp_sent_ff)) else $error("finished together with sent");
`endif

endmodule

/* hw/rtl/buffered_parallel_printer_feeder.sv */
// buffered_parallel_printer_feeder: top level of the printer feeder
// depends on bppf_pkg, bppf_front, bppf_back and bppf_ram
//
// A request carries either a character from software (req_mode 0) or a
// printer-ready interrupt (req_mode 1), with the sampled status byte in both.
// Each request produces exactly one response on the rsp_ channel, in order.
// A character is sent straight to the printer when the buffer is empty and
// the status is ready, queued when the buffer holds something and has room,
// and refused (rsp_accepted low, retry) otherwise. An interrupt with a ready
// status sends the oldest buffered character masked to 7 bits, or ends
// printing when the buffer is empty.
// A request passes the two-entry queue and then the response register; an
// interrupt that reads the buffer also passes the registered ram read.
// Throughput: one request per cycle, held by rsp_stall and by buffer reads.
// A two-entry queue separates intake from execution, so requests are still
// taken while a response waits; when rsp_stall holds, the response stays and
// req_stall rises once the queue is full.
// Synchronous reset empties the queue and the buffer and clears printing;
// buffer contents are not cleared.
module buffered_parallel_printer_feeder #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_printer_status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_sent,
   output logic [7:0] rsp_sent_byte,
   output logic       rsp_finished,
   output logic       rsp_accepted,
   output logic       rsp_busy_printing,
   output logic [7:0] rsp_fill_level
);

   bppf_pkg::link_type q_link;
   logic               q_take;

   bppf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_char_in        (req_char_in),
      .req_printer_status (req_printer_status),
      .q_link             (q_link),
      .q_take             (q_take)
   );

   bppf_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_link            (q_link),
      .q_take            (q_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sent          (rsp_sent),
      .rsp_sent_byte     (rsp_sent_byte),
      .rsp_finished      (rsp_finished),
      .rsp_accepted      (rsp_accepted),
      .rsp_busy_printing (rsp_busy_printing),
      .rsp_fill_level    (rsp_fill_level)
   );

endmodule
